// File: rtl/gradient_noise_2d_top_macros.svh
// Assertion macros for the gradient noise block.
// Included by modules that carry concurrent assertions.
`ifndef GRADIENT_NOISE_2D_TOP_MACROS_SVH
`define GRADIENT_NOISE_2D_TOP_MACROS_SVH

// implication checked on every clock, off during reset
`define GN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, off during reset
`define GN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/gn2d_pkg.sv
// Package for the gradient noise block: widths, queue sizes, item types, permutation ROM, 1/sqrt(2) constant.
// No dependencies.
`timescale 1ns / 1ps
package gn2d_pkg;
	localparam int LATTICE_BITS = 8;
	localparam int QDEPTH = 4;
	localparam int QAW = 2;
	localparam logic [16:0] INV_SQRT2_Q16 = 17'd46341;

	typedef struct packed {
		logic [2:0]  g00;
		logic [2:0]  g10;
		logic [2:0]  g01;
		logic [2:0]  g11;
		logic [15:0] tx;
		logic [15:0] ty;
	} gn2d_item_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic full;
		logic empty;
	} gn2d_qctl_t;

	localparam logic [7:0] PERM [256] = '{
		8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
		8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
		8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
		8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
		8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
		8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
		8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
		8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
		8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
		8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
		8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
		8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
		8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
		8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
		8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
		8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
		8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
		8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
		8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
		8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
		8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
		8'd215,8'd61,8'd156,8'd180
	};
endpackage

// File: rtl/gn2d_front.sv
// Front end: lattice cell split and two-level permutation lookup per corner.
// Depends on gn2d_pkg.
`timescale 1ns / 1ps
module gn2d_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic [31:0]            x_coord,
	input  logic [31:0]            y_coord,
	output logic                   out_valid,
	output gn2d_pkg::gn2d_item_t   out_item
);
	localparam logic [7:0] LMASK = 8'((1 << gn2d_pkg::LATTICE_BITS) - 1);

	logic [7:0] x0, y0, x1, y1;
	logic [7:0] px0_s1, px1_s1, y0_s1, y1_s1;
	logic [15:0] tx_s1, ty_s1;
	logic v_s1;

	assign x0 = x_coord[23:16] & LMASK;
	assign y0 = y_coord[23:16] & LMASK;
	assign x1 = (x0 + 8'd1) & LMASK;
	assign y1 = (y0 + 8'd1) & LMASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		px0_s1 <= gn2d_pkg::PERM[x0];
		px1_s1 <= gn2d_pkg::PERM[x1];
		y0_s1 <= y0;
		y1_s1 <= y1;
		tx_s1 <= x_coord[15:0];
		ty_s1 <= y_coord[15:0];
		out_item.g00 <= gn2d_pkg::PERM[8'(px0_s1 + y0_s1)][2:0];
		out_item.g10 <= gn2d_pkg::PERM[8'(px1_s1 + y0_s1)][2:0];
		out_item.g01 <= gn2d_pkg::PERM[8'(px0_s1 + y1_s1)][2:0];
		out_item.g11 <= gn2d_pkg::PERM[8'(px1_s1 + y1_s1)][2:0];
		out_item.tx <= tx_s1;
		out_item.ty <= ty_s1;
	end
endmodule

// File: rtl/gn2d_queue.sv
// Short FIFO of classified items between front and back ends.
// Depends on gn2d_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "gradient_noise_2d_top_macros.svh"
module gn2d_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  gn2d_pkg::gn2d_item_t   wdata,
	input  logic                   pop,
	output gn2d_pkg::gn2d_item_t   rdata,
	output gn2d_pkg::gn2d_qctl_t   ctl
);
	gn2d_pkg::gn2d_item_t mem_q [gn2d_pkg::QDEPTH];
	logic [gn2d_pkg::QAW-1:0] wp_q, rp_q;
	logic [gn2d_pkg::QAW:0] cnt_q;

	assign ctl.push = push;
	assign ctl.pop = pop;
	assign ctl.empty = (cnt_q == '0);
	assign ctl.full = (cnt_q == (gn2d_pkg::QAW+1)'(gn2d_pkg::QDEPTH));
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (gn2d_pkg::QAW+1)'(push) - (gn2d_pkg::QAW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	`GN_ASSERT_IMP(a_no_overflow, clk, arst_n, ctl.full && !pop, !push)
	`GN_ASSERT_IMP(a_no_underflow, clk, arst_n, ctl.empty, !pop)
	`GN_ASSERT_NEXT(a_cnt_step, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1)
endmodule

// File: rtl/gn2d_back.sv
// Back end: corner dot products, fade curves, three lerps, and a scale by 10.
// Depends on gn2d_pkg.
`timescale 1ns / 1ps
module gn2d_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  gn2d_pkg::gn2d_item_t   item,
	output logic                   out_valid,
	output logic [31:0]            noise_value
);
	function automatic logic signed [18:0] dotp(input logic [2:0] g,
		input logic signed [17:0] ox, input logic signed [17:0] oy);
		logic signed [18:0] r;
		unique case (g)
			3'd0: r = 19'(oy);
			3'd1: r = -19'(oy);
			3'd2: r = 19'(ox);
			3'd3: r = -19'(ox);
			3'd4: r = 19'(ox) + 19'(oy);
			3'd5: r = 19'(ox) - 19'(oy);
			3'd6: r = -19'(ox) + 19'(oy);
			default: r = -19'(ox) - 19'(oy);
		endcase
		return r;
	endfunction

	function automatic logic signed [18:0] div16(input logic signed [36:0] p);
		logic signed [36:0] a;
		a = p + ((p < 0) ? 37'sd65535 : 37'sd0);
		return 19'(a >>> 16);
	endfunction

	// stage 1: raw dots, t^2
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [18:0] r_s1 [4];
	logic [3:0] diag_s1;
	logic [15:0] tx_s1, ty_s1;
	logic [15:0] tx2_s1, ty2_s1;
	logic signed [18:0] d_s2 [4];
	logic [15:0] tx3_s2, ty3_s2;
	logic [19:0] px_s2, py_s2;
	logic [15:0] u_s3, v_s3, v_s4, v_s5;
	logic signed [18:0] d_s3 [4];
	logic signed [18:0] row0_s4, row1_s4, row0_s5;
	logic signed [19:0] dr_s5;
	logic signed [18:0] res_s6;
	logic signed [17:0] ox0, ox1, oy0, oy1;

	assign ox0 = 18'(item.tx);
	assign oy0 = 18'(item.ty);
	assign ox1 = 18'(item.tx) - 18'sd65536;
	assign oy1 = 18'(item.ty) - 18'sd65536;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6} <= '0;
		end else begin
			{vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6} <=
				{in_valid, vld_s1, vld_s2, vld_s3, vld_s4, vld_s5};
		end
	end

	always_ff @(posedge clk) begin
		r_s1[0] <= dotp(item.g00, ox0, oy0);
		r_s1[1] <= dotp(item.g10, ox1, oy0);
		r_s1[2] <= dotp(item.g01, ox0, oy1);
		r_s1[3] <= dotp(item.g11, ox1, oy1);
		diag_s1 <= {item.g11[2], item.g01[2], item.g10[2], item.g00[2]};
		tx_s1 <= item.tx;
		ty_s1 <= item.ty;
		tx2_s1 <= 16'((32'(item.tx) * 32'(item.tx)) >> 16);
		ty2_s1 <= 16'((32'(item.ty) * 32'(item.ty)) >> 16);
		// stage 2
		for (int i = 0; i < 4; i++)
			d_s2[i] <= diag_s1[i] ? div16(37'(r_s1[i]) * 37'sd46341) : r_s1[i];
		tx3_s2 <= 16'((32'(tx2_s1) * 32'(tx_s1)) >> 16);
		ty3_s2 <= 16'((32'(ty2_s1) * 32'(ty_s1)) >> 16);
		px_s2 <= 20'(6 * 21'(tx2_s1) + 21'd655360 - 15 * 21'(tx_s1));
		py_s2 <= 20'(6 * 21'(ty2_s1) + 21'd655360 - 15 * 21'(ty_s1));
		// stage 3
		u_s3 <= 16'((35'(tx3_s2) * 35'(px_s2)) >> 16);
		v_s3 <= 16'((35'(ty3_s2) * 35'(py_s2)) >> 16);
		d_s3 <= d_s2;
		// stage 4
		row0_s4 <= 19'(d_s3[0] + div16(37'(20'(d_s3[1]) - 20'(d_s3[0])) * 37'(u_s3)));
		row1_s4 <= 19'(d_s3[2] + div16(37'(20'(d_s3[3]) - 20'(d_s3[2])) * 37'(u_s3)));
		v_s4 <= v_s3;
		// stage 5
		dr_s5 <= 20'(row1_s4) - 20'(row0_s4);
		row0_s5 <= row0_s4;
		v_s5 <= v_s4;
		// stage 6
		res_s6 <= 19'(row0_s5 + div16(37'(dr_s5) * 37'(v_s5)));
	end

	assign out_valid = vld_s6;
	assign noise_value = 32'(res_s6) * 32'd10;
endmodule

// File: rtl/gradient_noise_2d_top.sv
// Top level of the 2D gradient noise block.
// Depends on gn2d_pkg, gn2d_front, gn2d_queue, gn2d_back.
//
// Usage:
//   Pulse start with x_coord/y_coord (signed Q16.16) while busy is low; a beat
//   is taken at that edge. busy stays low, so one point per cycle is taken.
//   Each beat yields one noise_value (10 * noise, Q16.16) marked by done for
//   one cycle, in input order.
//   Path: the front pipeline (permutation ROM lookups), then the queue, then
//   the back pipeline (dot, fade, lerps). Throughput one beat per cycle,
//   set by the fully pipelined front and back ends.
//   The receiver cannot stall: done beats are never held. The queue between
//   the ends is drained every cycle it holds an item.
//   Reset (arst_n low) clears all valid flags and the queue; no beat is lost
//   or invented after release.
`timescale 1ns / 1ps
`include "gradient_noise_2d_top_macros.svh"
module gradient_noise_2d_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] x_coord,
	input  logic [31:0] y_coord,
	output logic        done,
	output logic [31:0] noise_value
);
	logic fv;
	gn2d_pkg::gn2d_item_t fitem, qitem;
	gn2d_pkg::gn2d_qctl_t qctl;
	logic pop;

	assign busy = 1'b0;
	assign pop = !qctl.empty;

	gn2d_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy),
		.x_coord(x_coord), .y_coord(y_coord), .out_valid(fv), .out_item(fitem)
	);

	gn2d_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(fv), .wdata(fitem),
		.pop(pop), .rdata(qitem), .ctl(qctl)
	);

	gn2d_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(pop), .item(qitem),
		.out_valid(done), .noise_value(noise_value)
	);

	`GN_ASSERT_IMP(a_queue_never_full, clk, arst_n, 1'b1, !qctl.full)
	`GN_ASSERT_NEXT(a_pop_follows_push, clk, arst_n, fv, pop)
	`GN_ASSERT_IMP(a_pop_drains, clk, arst_n, qctl.empty, !pop)
endmodule
